>>> rtl/mdi_pkg.sv
// Shared types, codes and fixed-point helpers for the dense network inference block.
`default_nettype none

package mdi_pkg;

    localparam int DATA_BITS = 16;
    localparam int SZ_W      = 11;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;

    // item kinds
    localparam logic [2:0] KIND_DESC   = 3'd0;
    localparam logic [2:0] KIND_WEIGHT = 3'd1;
    localparam logic [2:0] KIND_BIAS   = 3'd2;
    localparam logic [2:0] KIND_INPUT  = 3'd3;
    localparam logic [2:0] KIND_READ   = 3'd4;

    // activation codes
    localparam logic [1:0] ACT_LINEAR = 2'd0;
    localparam logic [1:0] ACT_RELU   = 2'd1;
    localparam logic [1:0] ACT_TANH   = 2'd2;
    localparam logic [1:0] ACT_SPARE  = 2'd3;

    // configuration register indexes
    localparam logic CFG_NUM_LAYERS = 1'b0;
    localparam logic CFG_INPUT_SIZE = 1'b1;

    typedef struct packed {
        logic [2:0]         kind;
        logic [2:0]         layer;
        logic [18:0]        address;
        logic signed [15:0] value;
        logic [10:0]        neuron_count;
        logic [1:0]         activation;
        logic               last;
    } item_t;

    typedef struct packed {
        logic signed [15:0] result_value;
        logic [9:0]         result_index;
    } result_t;

    // classified command handed from front to engine
    typedef struct packed {
        logic [2:0]         op;
        logic               wr_ok;
        logic               last;
        logic [2:0]         layer;
        logic [18:0]        address;
        logic signed [15:0] value;
        logic [SZ_W-1:0]    neuron_count;
        logic [1:0]         activation;
    } cmd_t;

    typedef struct packed {
        logic evaluating;
        logic read_pending;
    } eng_stat_t;

    function automatic logic [11:0] tanh_knot(input logic [3:0] idx);
        logic [11:0] k;
        case (idx)
            4'd0:    k = 12'd0;
            4'd1:    k = 12'd946;
            4'd2:    k = 12'd1560;
            4'd3:    k = 12'd1854;
            4'd4:    k = 12'd1974;
            4'd5:    k = 12'd2021;
            4'd6:    k = 12'd2038;
            4'd7:    k = 12'd2044;
            default: k = 12'd2048;
        endcase
        return k;
    endfunction

    // odd-symmetric piecewise-linear tanh, knots every 0.5
    function automatic logic signed [15:0] tanh_pwl(input logic signed [15:0] x);
        logic [16:0]        a;
        logic [2:0]         seg;
        logic [9:0]         frac;
        logic [11:0]        k0;
        logic [11:0]        k1;
        logic [21:0]        t;
        logic [11:0]        y;
        logic signed [15:0] ys;
        a = x[15] ? (17'd0 - {x[15], x}) : {1'b0, x};
        if (a >= 17'd8192)
        begin
            y = 12'd2048;
        end
        else
        begin
            seg  = a[12:10];
            frac = a[9:0];
            k0   = tanh_knot({1'b0, seg});
            k1   = tanh_knot({1'b0, seg} + 4'd1);
            t    = 22'(k1 - k0) * 22'(frac) + 22'd512;
            y    = k0 + 12'(t >> 10);
        end
        ys = $signed({4'b0000, y});
        return x[15] ? 16'(-ys) : ys;
    endfunction

endpackage

`default_nettype wire

>>> rtl/mlp_dense_inference_top.sv
// Top level of the dense multilayer network inference block.
`default_nettype none

// Channel   Direction  Handshake             Beat
// item      in         item_valid/item_stall item_t: kind, layer, address, value, ...
// result    out        result_valid/result_stall result_t: result_value, result_index
// cfg       in         cfg_we                cfg_index selects, cfg_data carries value
//
// Loader and input beats retire one a cycle from a four-deep command queue while the
// engine is idle; a read hit goes through state S_RD, which registers its result beat.
// The input beat flagged last runs the whole network, each neuron in turn through
// bias fetch and load, one MAC a cycle from the weight read port, drain, round, activate.
// Asynchronous reset clears control, config and result registers; stores are not cleared.
// A held result stops the engine at the next read beat, and every beat behind it
// waits; the queue keeps taking beats until it is full.

module mlp_dense_inference_top
    import mdi_pkg::*;
#(
    parameter int MAX_LAYERS   = 8,
    parameter int MAX_WIDTH    = 1024,
    parameter int WEIGHT_WORDS = 524288
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire item_t       item,
    output logic             result_valid,
    input  wire logic        result_stall,
    output result_t          result,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [10:0] cfg_data
);

    logic [3:0]         num_layers_reg;
    logic [10:0]        input_size_reg;
    logic               cmd_valid;
    logic               cmd_pop;
    cmd_t               cmd;
    logic [Q_CNT_W-1:0] fq_count;
    eng_stat_t          stat;

    // configuration registers; user writes them only while idle, the block does not check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_layers_reg <= 4'd1;
            input_size_reg <= 11'd1024;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NUM_LAYERS: num_layers_reg <= cfg_data[3:0];
                CFG_INPUT_SIZE: input_size_reg <= cfg_data;
                default:        num_layers_reg <= num_layers_reg;
            endcase
        end
    end

    // front: classify and queue beats
    mdi_front #(
        .MAX_LAYERS   (MAX_LAYERS),
        .MAX_WIDTH    (MAX_WIDTH),
        .WEIGHT_WORDS (WEIGHT_WORDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cmd_valid  (cmd_valid),
        .cmd_pop    (cmd_pop),
        .cmd        (cmd),
        .fq_count   (fq_count)
    );

    // back: stores, evaluation and result register
    mdi_engine #(
        .MAX_LAYERS   (MAX_LAYERS),
        .MAX_WIDTH    (MAX_WIDTH),
        .WEIGHT_WORDS (WEIGHT_WORDS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_pop      (cmd_pop),
        .cmd          (cmd),
        .num_layers   (num_layers_reg),
        .input_size   (input_size_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .stat         (stat)
    );

    // queue occupancy never passes its depth
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fq_count <= Q_CNT_W'(Q_DEPTH))
        else $error("command queue overfilled");

    // no result appears while the network is being evaluated
    a_no_result_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
        stat.evaluating && !result_valid |=> !result_valid)
        else $error("result raised during evaluation");

    // a read that hit always delivers a beat next cycle
    a_read_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        stat.read_pending |=> result_valid)
        else $error("read hit lost");

endmodule

`default_nettype wire

>>> rtl/mdi_front.sv
// Front end: accepts item beats, classifies them and queues commands for the engine.
`default_nettype none

module mdi_front
    import mdi_pkg::*;
#(
    parameter int MAX_LAYERS   = 8,
    parameter int MAX_WIDTH    = 1024,
    parameter int WEIGHT_WORDS = 524288
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire item_t              item,
    output logic                    cmd_valid,
    input  wire logic               cmd_pop,
    output cmd_t                    cmd,
    output logic [Q_CNT_W-1:0]      fq_count
);

    cmd_t               q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wptr_reg;
    logic [Q_PTR_W-1:0] rptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    cmd_t               c;
    logic               keep;
    logic               push;

    always_comb
    begin
        c            = '0;
        c.op         = item.kind;
        c.last       = item.last;
        c.layer      = item.layer;
        c.address    = item.address;
        c.value      = item.value;
        c.activation = (item.activation == ACT_SPARE) ? ACT_LINEAR : item.activation;
        // clamp neuron count to 1..MAX_WIDTH
        if (item.neuron_count == '0)
            c.neuron_count = SZ_W'(1);
        else if (32'(item.neuron_count) > MAX_WIDTH)
            c.neuron_count = SZ_W'(MAX_WIDTH);
        else
            c.neuron_count = item.neuron_count;
        keep = 1'b1;
        unique case (item.kind)
            KIND_DESC:   c.wr_ok = 32'(item.layer) < MAX_LAYERS;
            KIND_WEIGHT: c.wr_ok = 32'(item.address) < WEIGHT_WORDS;
            KIND_BIAS:   c.wr_ok = (32'(item.layer) < MAX_LAYERS)
                                   && (32'(item.address) < MAX_WIDTH);
            KIND_INPUT:  c.wr_ok = 32'(item.address) < MAX_WIDTH;
            KIND_READ:   c.wr_ok = 1'b1;
            default:
            begin
                c.wr_ok = 1'b0;
                keep    = 1'b0;
            end
        endcase
    end

    assign item_stall = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign push       = item_valid && !item_stall && keep;
    assign cmd_valid  = (count_reg != '0);
    assign cmd        = q_mem[rptr_reg];
    assign fq_count   = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wptr_reg] <= c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (cmd_pop)
                rptr_reg <= rptr_reg + 1'b1;
            if (push && !cmd_pop)
                count_reg <= count_reg + 1'b1;
            else if (!push && cmd_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> rtl/mdi_engine.sv
// Back end: stores, layer sequencer with one shared MAC, and the result register.
`default_nettype none

module mdi_engine
    import mdi_pkg::*;
#(
    parameter int MAX_LAYERS   = 8,
    parameter int MAX_WIDTH    = 1024,
    parameter int WEIGHT_WORDS = 524288
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    output logic            cmd_pop,
    input  wire cmd_t       cmd,
    input  wire logic [3:0] num_layers,
    input  wire logic [10:0] input_size,
    output logic            result_valid,
    input  wire logic       result_stall,
    output result_t         result,
    output eng_stat_t       stat
);

    localparam int IDX_W = $clog2(MAX_WIDTH);
    localparam int WA_W  = $clog2(WEIGHT_WORDS);
    localparam int BA_W  = $clog2(MAX_LAYERS * MAX_WIDTH);
    localparam int AB_W  = $clog2(2 * MAX_WIDTH);
    localparam int LI_W  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int NL_W  = $clog2(MAX_LAYERS + 1);
    localparam int ACC_W = 2 * DATA_BITS + IDX_W + 2;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BIAS  = 3'd1;
    localparam logic [2:0] S_BINIT = 3'd2;
    localparam logic [2:0] S_MAC   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_ROUND = 3'd5;
    localparam logic [2:0] S_ACT   = 3'd6;
    localparam logic [2:0] S_RD    = 3'd7;

    logic signed [15:0] wmem [WEIGHT_WORDS];
    logic signed [15:0] bmem [MAX_LAYERS * MAX_WIDTH];
    logic signed [15:0] amem [2 * MAX_WIDTH];
    logic [SZ_W-1:0]    lsize [MAX_LAYERS];
    logic [1:0]         lact [MAX_LAYERS];

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [NL_W-1:0]     k_reg;
    logic [NL_W-1:0]     n_reg;
    logic [SZ_W-1:0]     o_reg;
    logic [SZ_W-1:0]     j_reg;
    logic [SZ_W-1:0]     fanin_reg;
    logic [WA_W-1:0]     wptr_reg;
    logic                v1_reg;
    logic                v2_reg;
    logic signed [31:0]  prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [15:0]  y_reg;
    logic                out_ok_reg;
    logic [SZ_W-1:0]     final_size_reg;
    logic                final_bank_reg;
    logic [9:0]          rd_idx_reg;
    result_t             res_reg;
    logic                res_valid_reg;

    logic signed [15:0]  w_q;
    logic signed [15:0]  b_q;
    logic signed [15:0]  a_q;
    logic [SZ_W-1:0]     outs;
    logic [1:0]          cur_act;
    logic [BA_W-1:0]     b_ra;
    logic [AB_W-1:0]     a_ra;
    logic                a_we;
    logic [AB_W-1:0]     a_wa;
    logic signed [15:0]  a_wd;
    logic                rd_hit;
    logic                start_eval;
    logic [NL_W-1:0]     n_clamp;
    logic [SZ_W-1:0]     fan_clamp;
    logic signed [ACC_W-1:0] rnd;
    logic signed [15:0]  y_sat;
    logic signed [15:0]  y_act;

    assign outs    = lsize[LI_W'(k_reg)];
    assign cur_act = lact[LI_W'(k_reg)];
    assign b_ra    = BA_W'(32'(k_reg) * MAX_WIDTH + 32'(o_reg));
    assign rd_hit  = out_ok_reg && (32'(cmd.address) < 32'(final_size_reg));

    always_comb
    begin
        if (num_layers == '0)
            n_clamp = NL_W'(1);
        else if (32'(num_layers) > MAX_LAYERS)
            n_clamp = NL_W'(MAX_LAYERS);
        else
            n_clamp = NL_W'(num_layers);
        if (input_size == '0)
            fan_clamp = SZ_W'(1);
        else if (32'(input_size) > MAX_WIDTH)
            fan_clamp = SZ_W'(MAX_WIDTH);
        else
            fan_clamp = input_size;
    end

    // pop and sequencing
    always_comb
    begin
        cmd_pop    = 1'b0;
        start_eval = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && (cmd.op != KIND_READ || !res_valid_reg))
                begin
                    cmd_pop = 1'b1;
                    if (cmd.op == KIND_INPUT && cmd.last)
                    begin
                        start_eval = 1'b1;
                        state_next = S_BIAS;
                    end
                    else if (cmd.op == KIND_READ && rd_hit)
                        state_next = S_RD;
                end
            end
            S_BIAS:  state_next = S_BINIT;
            S_BINIT: state_next = S_MAC;
            S_MAC:
            begin
                if (j_reg == fanin_reg - 1'b1)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                    state_next = S_ROUND;
            end
            S_ROUND: state_next = S_ACT;
            S_ACT:
            begin
                if (o_reg == outs - 1'b1 && k_reg == n_reg - 1'b1)
                    state_next = S_IDLE;
                else
                    state_next = S_BIAS;
            end
            S_RD:    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // round half up, saturate, activate
    always_comb
    begin
        rnd = (acc_reg + ACC_W'(1024)) >>> 11;
        if (rnd > $signed(ACC_W'(32767)))
            y_sat = 16'sd32767;
        else if (rnd < $signed(ACC_W'(-32768)))
            y_sat = -16'sd32768;
        else
            y_sat = 16'(rnd);
        case (cur_act)
            ACT_RELU: y_act = y_reg[15] ? 16'sd0 : y_reg;
            ACT_TANH: y_act = tanh_pwl(y_reg);
            default:  y_act = y_reg;
        endcase
    end

    // activation buffer ports
    always_comb
    begin
        if (state_reg == S_IDLE)
            a_ra = final_bank_reg ? AB_W'(MAX_WIDTH + 32'(IDX_W'(cmd.address)))
                                  : AB_W'(IDX_W'(cmd.address));
        else
            a_ra = k_reg[0] ? AB_W'(MAX_WIDTH + 32'(IDX_W'(j_reg)))
                            : AB_W'(IDX_W'(j_reg));
        if (state_reg == S_ACT)
        begin
            a_we = 1'b1;
            a_wa = k_reg[0] ? AB_W'(IDX_W'(o_reg))
                            : AB_W'(MAX_WIDTH + 32'(IDX_W'(o_reg)));
            a_wd = y_act;
        end
        else
        begin
            a_we = cmd_pop && cmd.op == KIND_INPUT && cmd.wr_ok;
            a_wa = AB_W'(IDX_W'(cmd.address));
            a_wd = cmd.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.op == KIND_WEIGHT && cmd.wr_ok)
            wmem[WA_W'(cmd.address)] <= cmd.value;
        w_q <= wmem[wptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.op == KIND_BIAS && cmd.wr_ok)
            bmem[BA_W'(32'(cmd.layer) * MAX_WIDTH + 32'(cmd.address))] <= cmd.value;
        b_q <= bmem[b_ra];
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
            amem[a_wa] <= a_wd;
        a_q <= amem[a_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.op == KIND_DESC && cmd.wr_ok)
        begin
            lsize[LI_W'(cmd.layer)] <= cmd.neuron_count;
            lact[LI_W'(cmd.layer)]  <= cmd.activation;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= w_q * a_q;
        if (state_reg == S_BINIT)
            acc_reg <= $signed(ACC_W'(b_q)) <<< 11;
        else if (v2_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        if (state_reg == S_ROUND)
            y_reg <= y_sat;
        if (state_reg == S_IDLE && cmd_pop)
            rd_idx_reg <= cmd.address[9:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            k_reg          <= '0;
            n_reg          <= '0;
            o_reg          <= '0;
            j_reg          <= '0;
            fanin_reg      <= '0;
            wptr_reg       <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            out_ok_reg     <= 1'b0;
            final_size_reg <= '0;
            final_bank_reg <= 1'b0;
            res_reg        <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= (state_reg == S_MAC);
            v2_reg    <= v1_reg;
            if (start_eval)
            begin
                n_reg     <= n_clamp;
                fanin_reg <= fan_clamp;
                k_reg     <= '0;
                o_reg     <= '0;
                j_reg     <= '0;
                wptr_reg  <= '0;
            end
            if (state_reg == S_MAC)
            begin
                // advance weight pointer, wrap at end of the store
                wptr_reg <= (wptr_reg == WA_W'(WEIGHT_WORDS - 1)) ? '0 : wptr_reg + 1'b1;
                j_reg    <= (j_reg == fanin_reg - 1'b1) ? '0 : j_reg + 1'b1;
            end
            if (state_reg == S_ACT)
            begin
                if (o_reg == outs - 1'b1)
                begin
                    o_reg <= '0;
                    if (k_reg == n_reg - 1'b1)
                    begin
                        out_ok_reg     <= 1'b1;
                        final_size_reg <= outs;
                        final_bank_reg <= ~k_reg[0];
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        fanin_reg <= outs;
                    end
                end
                else
                    o_reg <= o_reg + 1'b1;
            end
            if (state_reg == S_RD)
            begin
                res_reg.result_value <= a_q;
                res_reg.result_index <= rd_idx_reg;
                res_valid_reg        <= 1'b1;
            end
            else if (!result_stall)
                res_valid_reg <= 1'b0;
        end
    end

    assign result_valid      = res_valid_reg;
    assign result            = res_reg;
    assign stat.evaluating   = (state_reg != S_IDLE) && (state_reg != S_RD);
    assign stat.read_pending = (state_reg == S_RD);

endmodule

`default_nettype wire

>>> tb/sv/tb_mlp_dense_inference_top.sv
// Self-checking testbench for the dense network inference block: predicts every read result.
`default_nettype none

class mlp_scoreboard;
    // predicted state of the block
    shortint weights[int];
    shortint biases[int];
    int      layer_neurons[8];
    int      layer_act[8];
    int      act_bank[2][1024];
    int      layers_reg;
    int      fanin_reg;
    int      out_count;
    int      out_bank;
    bit      out_ready;
    // expected read results, oldest first
    mdi_pkg::result_t pending_reads[$];
    int      errors;
    int      mismatches;

    function new();
        layers_reg = 1;
        fanin_reg  = 1024;
        out_count  = 0;
        out_bank   = 0;
        out_ready  = 0;
        errors     = 0;
        mismatches = 0;
    endfunction

    function int clamp_size(int v, int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function void write_reg(logic idx, logic [10:0] data);
        if (idx == mdi_pkg::CFG_NUM_LAYERS)
            layers_reg = data[3:0];
        else
            fanin_reg = data;
    endfunction

    // round half up, then saturate to 16 bits
    function int round_to_q11(longint acc);
        longint q;
        q = (acc + 1024) >>> 11;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return int'(q);
    endfunction

    function int tanh_q11(int x);
        int knots[9] = '{0, 946, 1560, 1854, 1974, 2021, 2038, 2044, 2048};
        int a;
        int y;
        int seg;
        a = (x < 0) ? -x : x;
        if (a >= 8192)
            y = 2048;
        else
        begin
            seg = a >> 10;
            y = knots[seg] + (((knots[seg + 1] - knots[seg]) * (a & 1023) + 512) >> 10);
        end
        return (x < 0) ? -y : y;
    endfunction

    function void run_network();
        int     n;
        int     fan;
        int     outs;
        int     y;
        longint base;
        longint acc;
        longint wi;
        n    = clamp_size(layers_reg, 8);
        fan  = clamp_size(fanin_reg, 1024);
        base = 0;
        for (int k = 0; k < n; k++)
        begin
            outs = clamp_size(layer_neurons[k], 1024);
            for (int o = 0; o < outs; o++)
            begin
                acc = longint'(biases[k * 1024 + o]) * 2048;
                for (int j = 0; j < fan; j++)
                begin
                    wi = (base + longint'(o) * fan + j) % 524288;
                    acc += longint'(weights[int'(wi)]) * longint'(act_bank[k & 1][j]);
                end
                y = round_to_q11(acc);
                if (layer_act[k] == mdi_pkg::ACT_RELU && y < 0)
                    y = 0;
                else if (layer_act[k] == mdi_pkg::ACT_TANH)
                    y = tanh_q11(y);
                act_bank[(k + 1) & 1][o] = y;
            end
            base += longint'(outs) * fan;
            fan = outs;
        end
        out_count = fan;
        out_bank  = n & 1;
        out_ready = 1;
    endfunction

    // note an accepted item beat and queue the result it causes
    function void note_item(mdi_pkg::item_t it);
        mdi_pkg::result_t r;
        int v;
        v = $signed(it.value);
        case (it.kind)
            mdi_pkg::KIND_DESC:
            begin
                layer_neurons[it.layer] = clamp_size(it.neuron_count, 1024);
                layer_act[it.layer] = (it.activation == mdi_pkg::ACT_SPARE) ?
                                      mdi_pkg::ACT_LINEAR : it.activation;
            end
            mdi_pkg::KIND_WEIGHT:
                weights[it.address] = shortint'(v);
            mdi_pkg::KIND_BIAS:
                if (it.address < 1024)
                    biases[it.layer * 1024 + it.address] = shortint'(v);
            mdi_pkg::KIND_INPUT:
            begin
                if (it.address < 1024)
                    act_bank[0][it.address] = v;
                if (it.last)
                    run_network();
            end
            mdi_pkg::KIND_READ:
                if (out_ready && it.address < out_count)
                begin
                    r.result_value = 16'(act_bank[out_bank][it.address]);
                    r.result_index = it.address[9:0];
                    pending_reads = {pending_reads, r};
                end
            default:
                ;
        endcase
    endfunction

    function void check_result(mdi_pkg::result_t got);
        mdi_pkg::result_t want;
        if (pending_reads.size() == 0)
        begin
            errors++;
            if (mismatches++ < 10)
                $display("unexpected result value %0d index %0d",
                         got.result_value, got.result_index);
            return;
        end
        want = pending_reads.pop_front();
        if (got.result_value !== want.result_value || got.result_index !== want.result_index)
        begin
            errors++;
            if (mismatches++ < 10)
                $display("result mismatch: expected value %0d index %0d, got value %0d index %0d",
                         want.result_value, want.result_index,
                         got.result_value, got.result_index);
        end
    endfunction
endclass

module tb_mlp_dense_inference_top;
    import mdi_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 300;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    item_t       item;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        cfg_we;
    logic        cfg_index;
    logic [10:0] cfg_data;

    mlp_scoreboard sb;
    bit            gaps_on;
    bit            rx_quiet;
    int            beats_sent;
    int            rx_hold;
    int            quiet_cycles;
    bit            input_seen[1024];

    mlp_dense_inference_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #4 clk = ~clk;
    end

    // Result side: draw a random stall hold per beat, check each accepted beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                sb.check_result(result);
                rx_hold = rx_quiet ? 0 : $urandom_range(0, 5);
                result_stall <= (rx_hold > 0);
            end
            else if (rx_hold > 0)
            begin
                rx_hold--;
                result_stall <= (rx_hold > 0);
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
                $display("tb_mlp_dense_inference_top failed");
                $finish;
            end
        end
    end

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2, 3:    return 16'($urandom_range(0, 4095) - 2048);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // random filler in every field, then set the ones that matter
    function automatic item_t make_beat(logic [2:0] kind);
        item_t it;
        it = item_t'({$urandom, $urandom});
        it.kind = kind;
        return it;
    endfunction

    // Present one beat after a random gap; hold it until it is taken.
    task automatic send(item_t it);
        int gap;
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_item(it);
        beats_sent++;
    endtask

    // Drop valid, wait for every queued read result, then let trailing beats drain.
    task automatic wait_idle();
        item_valid <= 1'b0;
        while (sb.pending_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Raise the write for one edge; the caller drops cfg_we after its last write.
    task automatic cfg_write(logic idx, logic [10:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // Noise beats; apart from weight writes, none disturbs what the coming evaluation reads.
    task automatic send_noise(int n_used);
        item_t it;
        case ($urandom_range(0, 4))
            0:
                it = make_beat(3'($urandom_range(5, 7)));
            1:
            begin
                it = make_beat(KIND_DESC);
                if (n_used < 8)
                    it.layer = 3'($urandom_range(n_used, 7));
                else
                    it.kind = 3'd7;
            end
            2:
            begin
                it = make_beat(KIND_BIAS);
                it.address = 19'($urandom_range(1024, 524287));
            end
            3:
                it = make_beat(KIND_READ);
            default:
                it = make_beat(KIND_WEIGHT);
        endcase
        send(it);
    endtask

    // One idle-to-idle run: program registers, load a network, evaluate, read back.
    task automatic run_phase(int n_raw, int in_raw, int max_out);
        item_t it;
        int    n;
        int    fan;
        int    fan0;
        int    outs;
        int    base;
        int    picks[$];
        bit    ignored_last;
        wait_idle();
        cfg_write(CFG_NUM_LAYERS, 11'(n_raw));
        cfg_write(CFG_INPUT_SIZE, 11'(in_raw));
        cfg_we   <= 1'b0;
        gaps_on  = ($urandom_range(0, 3) != 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
        n    = sb.clamp_size(n_raw & 15, 8);
        fan0 = sb.clamp_size(in_raw, 1024);
        fan  = fan0;
        base = 0;
        for (int k = 0; k < n; k++)
        begin
            it = make_beat(KIND_DESC);
            it.layer = 3'(k);
            it.neuron_count = 11'($urandom_range(0, max_out));
            send(it);
            outs = sb.clamp_size(it.neuron_count, 1024);
            for (int o = 0; o < outs; o++)
            begin
                it = make_beat(KIND_BIAS);
                it.layer = 3'(k);
                it.address = 19'(o);
                it.value = pick_value();
                send(it);
            end
            for (int w = 0; w < outs * fan; w++)
            begin
                it = make_beat(KIND_WEIGHT);
                it.address = 19'(base + w);
                it.value = ($urandom_range(0, 3) == 0) ? pick_value()
                                                       : 16'($urandom_range(0, 2047) - 1024);
                send(it);
            end
            base += outs * fan;
            fan = outs;
        end
        repeat ($urandom_range(0, 4)) send_noise(n);
        // inputs never written go in; the rest are stale or rewritten at random
        for (int j = 0; j < fan0; j++)
            if (!input_seen[j] || $urandom_range(0, 3) != 0)
                picks = {picks, j};
        ignored_last = (picks.size() == 0) || ($urandom_range(0, 5) == 0);
        foreach (picks[i])
        begin
            it = make_beat(KIND_INPUT);
            it.address = 19'(picks[i]);
            it.value = pick_value();
            it.last = !ignored_last && (i == picks.size() - 1);
            input_seen[picks[i]] = 1'b1;
            send(it);
        end
        if (ignored_last)
        begin
            it = make_beat(KIND_INPUT);
            it.address = 19'($urandom_range(1024, 524287));
            it.last = 1'b1;
            send(it);
        end
        // first read always valid, later ones may fall outside the output
        it = make_beat(KIND_READ);
        it.address = 19'($urandom_range(0, fan - 1));
        send(it);
        repeat ($urandom_range(0, 5))
        begin
            it = make_beat(KIND_READ);
            if ($urandom_range(0, 3) != 0)
                it.address = 19'($urandom_range(0, fan - 1));
            send(it);
        end
    endtask

    initial
    begin
        item_t it;
        sb           = new();
        rst_n        = 1'b0;
        item_valid  <= 1'b0;
        item        <= '0;
        result_stall <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= 1'b0;
        cfg_data    <= '0;
        gaps_on      = 1'b0;
        rx_quiet     = 1'b1;
        rx_hold      = 0;
        quiet_cycles = 0;
        beats_sent   = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reads before any evaluation and unknown kinds produce nothing
        it = make_beat(KIND_READ);
        it.address = '0;
        send(it);
        for (int k = 5; k <= 7; k++)
            send(make_beat(3'(k)));

        // zero sizes clamp to one, oversized layer count clamps to eight
        run_phase(0, 0, 0);
        run_phase(15, 3, 3);
        run_phase(8, 1, 2047 > 0 ? 2 : 0);

        while (beats_sent < 1700)
        begin
            if ($urandom_range(0, 2) == 0)
                run_phase($urandom_range(0, 15), $urandom_range(0, 4), 3);
            else
                run_phase($urandom_range(0, 3), $urandom_range(0, 12), 6);
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending_reads.size() == 0)
            $display("tb_mlp_dense_inference_top passed");
        else
            $display("tb_mlp_dense_inference_top failed");
        $finish;
    end

endmodule

`default_nettype wire
